// ----- hdl/imsc_pkg.sv -----
`default_nettype none
package imsc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int ANG_SHIFT     = 30 - FRAC_BITS;
  localparam int ANG_W         = 48;
  localparam int CW            = 36;

  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_SIN = 2'd1,
    MODE_COS = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  localparam logic signed [ANG_W-1:0] Q30_PI            = 48'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI       = 48'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_THREE_HALF_PI = 48'sd5059889139;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI        = 48'sd6746518852;
  localparam logic signed [ANG_W-1:0] Q30_ANGLE_LIMIT   = 48'sd6746856178;
  localparam logic signed [CW-1:0]    Q30_GAIN          = 36'sd652032874;
  localparam logic signed [31:0]      ONE_Q             = 32'sd1 <<< FRAC_BITS;

  // Arctangent table, atan(2^-i) in Q.30, truncated.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return CW'(signed'({1'b0, v}));
  endfunction

  // Per-stage flags carried with each beat through the pipeline.
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       wrap_hi;
    logic       wrap_lo;
  } imsc_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/imsc_if.sv -----
`default_nettype none
interface imsc_in_if (input wire logic clk);
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [31:0] a_low;
  logic signed [31:0] a_high;
  logic signed [31:0] b_low;
  logic signed [31:0] b_high;
  modport source (output valid, mode, a_low, a_high, b_low, b_high, input ready);
  modport sink   (input valid, mode, a_low, a_high, b_low, b_high, output ready);
endinterface

interface imsc_out_if (input wire logic clk);
  logic              valid;
  logic              ready;
  logic signed [31:0] res_low;
  logic signed [31:0] res_high;
  logic              saturated;
  logic              error;
  modport source (output valid, res_low, res_high, saturated, error, input ready);
  modport sink   (input valid, res_low, res_high, saturated, error, output ready);
endinterface
`default_nettype wire

// ----- hdl/imsc_cordic_stage.sv -----
`default_nettype none
// One CORDIC rotation for one angle, registered, with stall enable.
module imsc_cordic_stage (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [4:0]                     idx,
  input  wire logic signed [imsc_pkg::CW-1:0] x_in,
  input  wire logic signed [imsc_pkg::CW-1:0] y_in,
  input  wire logic signed [imsc_pkg::CW-1:0] z_in,
  output logic signed [imsc_pkg::CW-1:0]      x_r,
  output logic signed [imsc_pkg::CW-1:0]      y_r,
  output logic signed [imsc_pkg::CW-1:0]      z_r
);
  import imsc_pkg::*;

  logic signed [CW-1:0] dx, dy, at;

  // Arithmetic shifts floor, matching the rotation definition.
  always_comb begin
    dx = y_in >>> idx;
    dy = x_in >>> idx;
    at = atan_q30(int'(idx));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[CW-1]) begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - at;
      end else begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + at;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/interval_mul_sin_cos_unit_top.sv -----
`default_nettype none
// A beat passes the stage-0 register, the CORDIC_STAGES rotation stages, then the output register.
// Throughput: one beat per cycle; the whole datapath advances on a single enable
// driven by the output register being empty or taken.
// The multiply path runs in step with the CORDIC chain so both share one pipeline.
// Reset (synchronous, active low) clears every valid bit; payload is not reset.
module interval_mul_sin_cos_unit_top (
  input wire logic clk,
  input wire logic rst_n,
  imsc_in_if.sink    in_ch,
  imsc_out_if.source out_ch
);
  import imsc_pkg::*;

  localparam int NS  = CORDIC_STAGES;
  localparam int LAT = NS + 2;

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------- Stage 0: order endpoints, classify ----------
  logic signed [31:0] al, ah, bl, bh;
  logic signed [ANG_W-1:0] ql, qh;
  always_comb begin
    al = (in_ch.a_low < in_ch.a_high) ? in_ch.a_low : in_ch.a_high;
    ah = (in_ch.a_low < in_ch.a_high) ? in_ch.a_high : in_ch.a_low;
    bl = (in_ch.b_low < in_ch.b_high) ? in_ch.b_low : in_ch.b_high;
    bh = (in_ch.b_low < in_ch.b_high) ? in_ch.b_high : in_ch.b_low;
    ql = ANG_W'(al) <<< ANG_SHIFT;
    qh = ANG_W'(ah) <<< ANG_SHIFT;
  end

  imsc_ctl_t c0_nxt;
  always_comb begin
    c0_nxt.mode = in_ch.mode;
    c0_nxt.err  = (in_ch.mode == MODE_RSV) ||
                  ((in_ch.mode != MODE_MUL) && (al < 0 || qh > Q30_ANGLE_LIMIT));
    c0_nxt.wrap_hi = (in_ch.mode == MODE_SIN) ? (ql < Q30_HALF_PI && qh > Q30_HALF_PI)
                                               : 1'b0;
    c0_nxt.wrap_lo = (in_ch.mode == MODE_SIN) ?
                     (ql < Q30_THREE_HALF_PI && qh > Q30_THREE_HALF_PI) :
                     (ql < Q30_PI && qh > Q30_PI);
  end

  // Quadrant folding for the two angles.
  logic signed [CW-1:0] zl0, zh0;
  logic fl0, fh0;
  always_comb begin
    fl0 = 1'b0; zl0 = CW'(ql);
    if (ql > Q30_HALF_PI && ql <= Q30_THREE_HALF_PI) begin
      zl0 = CW'(ql - Q30_PI); fl0 = 1'b1;
    end else if (ql > Q30_THREE_HALF_PI) begin
      zl0 = CW'(ql - Q30_TWO_PI);
    end
    fh0 = 1'b0; zh0 = CW'(qh);
    if (qh > Q30_HALF_PI && qh <= Q30_THREE_HALF_PI) begin
      zh0 = CW'(qh - Q30_PI); fh0 = 1'b1;
    end else if (qh > Q30_THREE_HALF_PI) begin
      zh0 = CW'(qh - Q30_TWO_PI);
    end
  end

  // Stage-0 registers.
  imsc_ctl_t ctl_r [LAT];
  logic [LAT-1:0] fl_r, fh_r;
  logic signed [CW-1:0] zl_r, zh_r;
  logic signed [31:0] al_r, ah_r, bl_r, bh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= c0_nxt;
      fl_r[0]  <= fl0;
      fh_r[0]  <= fh0;
      zl_r <= zl0; zh_r <= zh0;
      al_r <= al; ah_r <= ah; bl_r <= bl; bh_r <= bh;
      for (int k = 1; k < LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
        fl_r[k]  <= fl_r[k-1];
        fh_r[k]  <= fh_r[k-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---------- CORDIC chains, one per endpoint ----------
  logic signed [CW-1:0] xl [NS+1], yl [NS+1], zl [NS+1];
  logic signed [CW-1:0] xh [NS+1], yh [NS+1], zh [NS+1];
  assign xl[0] = Q30_GAIN; assign yl[0] = '0; assign zl[0] = zl_r;
  assign xh[0] = Q30_GAIN; assign yh[0] = '0; assign zh[0] = zh_r;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    imsc_cordic_stage u_lo (
      .clk(clk), .en(en), .idx(5'(g)),
      .x_in(xl[g]), .y_in(yl[g]), .z_in(zl[g]),
      .x_r(xl[g+1]), .y_r(yl[g+1]), .z_r(zl[g+1])
    );
    imsc_cordic_stage u_hi (
      .clk(clk), .en(en), .idx(5'(g)),
      .x_in(xh[g]), .y_in(yh[g]), .z_in(zh[g]),
      .x_r(xh[g+1]), .y_r(yh[g+1]), .z_r(zh[g+1])
    );
  end

  // ---------- Multiply path: products, then min/max, then round ----------
  logic signed [63:0] p_r [4];
  logic signed [63:0] pmin_r, pmax_r;
  logic signed [63:0] mlo_r, mhi_r;
  logic signed [63:0] pmin_nxt, pmax_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= al_r * bl_r;
      p_r[1] <= al_r * bh_r;
      p_r[2] <= ah_r * bl_r;
      p_r[3] <= ah_r * bh_r;
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;
    end
  end

  always_comb begin
    pmin_nxt = p_r[0];
    pmax_nxt = p_r[0];
    for (int k = 1; k < 4; k++) begin
      if (p_r[k] < pmin_nxt) pmin_nxt = p_r[k];
      if (p_r[k] > pmax_nxt) pmax_nxt = p_r[k];
    end
  end

  // Delay line aligning the multiply result with the CORDIC output.
  localparam int MD = NS - 3;
  logic signed [63:0] mdl_r [MD+1];
  logic signed [63:0] mdh_r [MD+1];
  always_ff @(posedge clk) begin
    if (en) begin
      mdl_r[0] <= pmin_r;
      mdh_r[0] <= pmax_r;
      for (int k = 1; k <= MD; k++) begin
        mdl_r[k] <= mdl_r[k-1];
        mdh_r[k] <= mdh_r[k-1];
      end
    end
  end
  assign mlo_r = mdl_r[MD];
  assign mhi_r = mdh_r[MD];

  // ---------- Final stage: round, sort, widen, saturate, select ----------
  imsc_ctl_t cf;
  logic ffl, ffh;
  assign cf  = ctl_r[LAT-2];
  assign ffl = fl_r[LAT-2];
  assign ffh = fh_r[LAT-2];

  logic signed [CW-1:0] sl_q, sh_q, cl_q, ch_q;
  logic signed [CW-1:0] sl, sh, cl, ch, tlo, thi;
  logic signed [63:0] rlo, rhi;
  logic signed [31:0] res_lo_nxt, res_hi_nxt;
  logic sat_nxt;
  logic signed [CW-1:0] half;

  always_comb begin
    half = CW'(1) <<< (ANG_SHIFT - 1);
    sl_q = ffl ? -yl[NS] : yl[NS];
    cl_q = ffl ? -xl[NS] : xl[NS];
    sh_q = ffh ? -yh[NS] : yh[NS];
    ch_q = ffh ? -xh[NS] : xh[NS];
    sl = (sl_q + half) >>> ANG_SHIFT;
    cl = (cl_q + half) >>> ANG_SHIFT;
    sh = (sh_q + half) >>> ANG_SHIFT;
    ch = (ch_q + half) >>> ANG_SHIFT;
    if (cf.mode == MODE_SIN) begin
      tlo = (sl < sh) ? sl : sh; thi = (sl < sh) ? sh : sl;
      if (cf.wrap_hi) thi = CW'(ONE_Q);
      if (cf.wrap_lo) tlo = -CW'(ONE_Q);
    end else begin
      tlo = (cl < ch) ? cl : ch; thi = (cl < ch) ? ch : cl;
      if (cf.wrap_lo) tlo = -CW'(ONE_Q);
    end
    rlo = (mlo_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rhi = (mhi_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sat_nxt = 1'b0;
    if (cf.err) begin
      res_lo_nxt = '0; res_hi_nxt = '0;
    end else if (cf.mode == MODE_MUL) begin
      if (rlo > 64'sh7FFFFFFF) begin
        res_lo_nxt = 32'sh7FFFFFFF; sat_nxt = 1'b1;
      end else if (rlo < -64'sh80000000) begin
        res_lo_nxt = 32'sh80000000; sat_nxt = 1'b1;
      end else begin
        res_lo_nxt = rlo[31:0];
      end
      if (rhi > 64'sh7FFFFFFF) begin
        res_hi_nxt = 32'sh7FFFFFFF; sat_nxt = 1'b1;
      end else if (rhi < -64'sh80000000) begin
        res_hi_nxt = 32'sh80000000; sat_nxt = 1'b1;
      end else begin
        res_hi_nxt = rhi[31:0];
      end
    end else begin
      res_lo_nxt = tlo[31:0];
      res_hi_nxt = thi[31:0];
    end
  end

  // Output register: holds a beat until taken.
  logic signed [31:0] res_lo_r, res_hi_r;
  logic sat_r, err_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[LAT-2];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_lo_r <= res_lo_nxt;
      res_hi_r <= res_hi_nxt;
      sat_r    <= sat_nxt;
      err_r    <= cf.err;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.res_low   = res_lo_r;
  assign out_ch.res_high  = res_hi_r;
  assign out_ch.saturated = sat_r;
  assign out_ch.error     = err_r;

  // Unused tail of the shift lines.
  logic unused_tail;
  assign unused_tail = vld_r[LAT-1] ^ ctl_r[LAT-1].err ^ fl_r[LAT-1] ^ fh_r[LAT-1];

  // ---------- Assertions ----------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.res_low == 0 && out_ch.res_high == 0
      && !out_ch.saturated) else $error("error beat with non-zero bounds");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res_low))
    else $error("stalled result changed");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.res_low <= out_ch.res_high)
    else $error("result interval inverted");
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");
endmodule
`default_nettype wire
